// ===== hw/rtl/ps2kmc_pkg.sv =====
package ps2kmc_pkg;

  // Queue sizes and the pointer and count widths they imply
  localparam int KBD_FIFO_DEPTH = 16;
  localparam int AUX_FIFO_DEPTH = 16;
  localparam int KBD_AW = $clog2(KBD_FIFO_DEPTH);
  localparam int AUX_AW = $clog2(AUX_FIFO_DEPTH);
  localparam int KBD_CW = $clog2(KBD_FIFO_DEPTH + 1);
  localparam int AUX_CW = $clog2(AUX_FIFO_DEPTH + 1);

  // Bus operations
  typedef enum logic [2:0] {
    OP_READ_STATUS = 3'd0,
    OP_READ_DATA   = 3'd1,
    OP_WRITE_DATA  = 3'd2,
    OP_WRITE_CMD   = 3'd3,
    OP_PUSH_KBD    = 3'd4,
    OP_PUSH_AUX    = 3'd5
  } op_t;

  // What the next data port write means
  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_CONFIG = 2'd1,
    PEND_AUX    = 2'd2
  } pend_t;

  // Controller commands
  localparam logic [7:0] CMD_READ_CONFIG  = 8'h20;
  localparam logic [7:0] CMD_WRITE_CONFIG = 8'h60;
  localparam logic [7:0] CMD_AUX_DISABLE  = 8'hA7;
  localparam logic [7:0] CMD_AUX_ENABLE   = 8'hA8;
  localparam logic [7:0] CMD_AUX_TEST     = 8'hA9;
  localparam logic [7:0] CMD_SELF_TEST    = 8'hAA;
  localparam logic [7:0] CMD_KBD_TEST     = 8'hAB;
  localparam logic [7:0] CMD_WRITE_AUX    = 8'hD4;

  // Device bytes and replies
  localparam logic [7:0] BYTE_ACK       = 8'hFA;
  localparam logic [7:0] BYTE_BAT_OK    = 8'hAA;
  localparam logic [7:0] BYTE_SELF_OK   = 8'h55;
  localparam logic [7:0] BYTE_TEST_OK   = 8'h00;
  localparam logic [7:0] BYTE_DEV_RESET = 8'hFF;
  localparam logic [7:0] CFG_AUX_OFF    = 8'h20;

  // Status byte bits
  localparam logic [7:0] STAT_OBF  = 8'h01;
  localparam logic [7:0] STAT_SYS  = 8'h04;
  localparam logic [7:0] STAT_AUXB = 8'h20;

  // Decoded actions for one request
  typedef struct packed {
    logic       rd_status;
    logic       rd_data;
    logic       refill;
    logic       kbd_push;
    logic       kbd_push2;
    logic [7:0] kbd_byte;
    logic       aux_push;
    logic [7:0] aux_byte;
    logic       pend_we;
    pend_t      pend_next;
    logic       cfg_we;
    logic [7:0] cfg_next;
  } dec_t;

endpackage

// ===== hw/rtl/ps2kmc_decode.sv =====
module ps2kmc_decode import ps2kmc_pkg::*; (
  input  logic [2:0] op,
  input  logic [7:0] wdata,
  input  pend_t      pending_code,
  input  logic [7:0] ctrl_config,
  output dec_t       dec
);

  // Turn one bus operation into queue, buffer and register actions
  always_comb begin
    dec           = '0;
    dec.pend_next = PEND_NONE;
    dec.kbd_byte  = BYTE_ACK;
    dec.aux_byte  = BYTE_ACK;
    dec.cfg_next  = ctrl_config;
    unique case (op_t'(op))
      OP_READ_STATUS: dec.rd_status = 1'b1;
      OP_READ_DATA: begin
        dec.rd_data = 1'b1;
        dec.refill  = 1'b1;
      end
      OP_WRITE_DATA: begin
        unique case (pending_code)
          PEND_CONFIG: begin
            dec.cfg_we   = 1'b1;
            dec.cfg_next = wdata;
            dec.pend_we  = 1'b1;
          end
          PEND_AUX: begin
            dec.pend_we  = 1'b1;
            dec.aux_push = 1'b1;
            dec.refill   = 1'b1;
          end
          default: begin
            // keyboard acks; a device reset also reports self-test passed
            dec.kbd_push  = 1'b1;
            dec.kbd_push2 = (wdata == BYTE_DEV_RESET);
            dec.refill    = 1'b1;
          end
        endcase
      end
      OP_WRITE_CMD: begin
        unique case (wdata)
          CMD_READ_CONFIG: begin
            dec.kbd_push = 1'b1;
            dec.kbd_byte = ctrl_config;
            dec.refill   = 1'b1;
          end
          CMD_WRITE_CONFIG: begin
            dec.pend_we   = 1'b1;
            dec.pend_next = PEND_CONFIG;
          end
          CMD_AUX_DISABLE: begin
            dec.cfg_we   = 1'b1;
            dec.cfg_next = ctrl_config | CFG_AUX_OFF;
          end
          CMD_AUX_ENABLE: begin
            dec.cfg_we   = 1'b1;
            dec.cfg_next = ctrl_config & ~CFG_AUX_OFF;
          end
          CMD_SELF_TEST: begin
            dec.kbd_push = 1'b1;
            dec.kbd_byte = BYTE_SELF_OK;
            dec.refill   = 1'b1;
          end
          CMD_AUX_TEST, CMD_KBD_TEST: begin
            dec.kbd_push = 1'b1;
            dec.kbd_byte = BYTE_TEST_OK;
            dec.refill   = 1'b1;
          end
          CMD_WRITE_AUX: begin
            dec.pend_we   = 1'b1;
            dec.pend_next = PEND_AUX;
          end
          default: ;
        endcase
      end
      OP_PUSH_KBD: begin
        dec.kbd_push = 1'b1;
        dec.kbd_byte = wdata;
        dec.refill   = 1'b1;
      end
      OP_PUSH_AUX: begin
        dec.aux_push = 1'b1;
        dec.aux_byte = wdata;
        dec.refill   = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ps2_keyboard_mouse_controller.sv =====
// A request passes through the request register, then the result register,
// before its result is valid.
// Throughput: one request per cycle while res_stall does not hold it back; the
// queue update and buffer refill for a request complete in the cycle it leaves the request register.
// Reset (rst, synchronous): buffer empty, queues empty, config and pending
// command cleared, both pipeline stages empty.
module ps2_keyboard_mouse_controller import ps2kmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [2:0] op,
  input  logic [7:0] wdata,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] rdata,
  output logic       irq_kbd,
  output logic       irq_aux
);

  function automatic logic [KBD_AW-1:0] kbd_inc(input logic [KBD_AW-1:0] p);
    kbd_inc = (p == KBD_AW'(KBD_FIFO_DEPTH - 1)) ? '0 : p + KBD_AW'(1);
  endfunction

  function automatic logic [AUX_AW-1:0] aux_inc(input logic [AUX_AW-1:0] p);
    aux_inc = (p == AUX_AW'(AUX_FIFO_DEPTH - 1)) ? '0 : p + AUX_AW'(1);
  endfunction

  // Request register
  logic       s1_valid;
  logic [2:0] s1_op;
  logic [7:0] s1_wdata;
  logic       s1_move;

  // Controller state
  logic [7:0]        out_byte;
  logic              out_full;
  logic              out_from_aux;
  pend_t             pending_code;
  logic [7:0]        ctrl_config;
  logic [7:0]        kbd_fifo [KBD_FIFO_DEPTH];
  logic [7:0]        aux_fifo [AUX_FIFO_DEPTH];
  logic [KBD_CW-1:0] kbd_count, kbd_count_next;
  logic [AUX_CW-1:0] aux_count, aux_count_next;
  logic [KBD_AW-1:0] kbd_head, kbd_tail, kbd_tail_next, kbd_tail1;
  logic [AUX_AW-1:0] aux_head, aux_tail;

  dec_t       dec;
  logic       kbd_p0, kbd_p1, aux_p0;
  logic       kbd_avail, aux_avail, full_mid, refill_ok, kbd_pop, aux_pop;
  logic [7:0] kbd_front, aux_front, status, rdata_next;

  // Advance the request register when the result slot is free or drains
  assign s1_move   = s1_valid && (!res_valid || !res_stall);
  assign req_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (req_valid && !req_stall) || (s1_valid && !s1_move);
    end
    if (req_valid && !req_stall) begin
      s1_op    <= op;
      s1_wdata <= wdata;
    end
  end

  ps2kmc_decode u_decode (
    .op          (s1_op),
    .wdata       (s1_wdata),
    .pending_code(pending_code),
    .ctrl_config (ctrl_config),
    .dec         (dec)
  );

  // Pushes; a second keyboard byte needs room after the first
  assign kbd_p0    = dec.kbd_push && (kbd_count != KBD_CW'(KBD_FIFO_DEPTH));
  assign kbd_p1    = dec.kbd_push2 && kbd_p0 &&
                     (kbd_count != KBD_CW'(KBD_FIFO_DEPTH - 1));
  assign aux_p0    = dec.aux_push && (aux_count != AUX_CW'(AUX_FIFO_DEPTH));
  assign kbd_tail1 = kbd_inc(kbd_tail);
  assign kbd_tail_next = kbd_p1 ? kbd_inc(kbd_tail1) : (kbd_p0 ? kbd_tail1 : kbd_tail);

  // Refill the buffer, keyboard first; bypass a byte pushed into an empty queue
  assign kbd_avail = (kbd_count != '0) || kbd_p0;
  assign aux_avail = (aux_count != '0) || aux_p0;
  assign full_mid  = out_full && !dec.rd_data;
  assign refill_ok = dec.refill && !full_mid;
  assign kbd_pop   = refill_ok && kbd_avail;
  assign aux_pop   = refill_ok && !kbd_avail && aux_avail;
  assign kbd_front = (kbd_count == '0) ? dec.kbd_byte : kbd_fifo[kbd_head];
  assign aux_front = (aux_count == '0) ? dec.aux_byte : aux_fifo[aux_head];

  assign kbd_count_next = kbd_count + KBD_CW'(kbd_p0) + KBD_CW'(kbd_p1) - KBD_CW'(kbd_pop);
  assign aux_count_next = aux_count + AUX_CW'(aux_p0) - AUX_CW'(aux_pop);

  // Status and read data as they stand before this request
  assign status = STAT_SYS | (out_full ? STAT_OBF : 8'h00) |
                  (out_from_aux ? STAT_AUXB : 8'h00);
  assign rdata_next = dec.rd_status ? status : (dec.rd_data ? out_byte : 8'h00);

  // Update controller state once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_byte     <= 8'h00;
      out_full     <= 1'b0;
      out_from_aux <= 1'b0;
      pending_code <= PEND_NONE;
      ctrl_config  <= 8'h00;
      kbd_count    <= '0;
      aux_count    <= '0;
      kbd_head     <= '0;
      kbd_tail     <= '0;
      aux_head     <= '0;
      aux_tail     <= '0;
    end else if (s1_move) begin
      out_full  <= full_mid || kbd_pop || aux_pop;
      kbd_count <= kbd_count_next;
      aux_count <= aux_count_next;
      kbd_tail  <= kbd_tail_next;
      if (aux_p0) aux_tail <= aux_inc(aux_tail);
      if (dec.pend_we) pending_code <= dec.pend_next;
      if (dec.cfg_we) ctrl_config <= dec.cfg_next;
      if (kbd_pop) begin
        out_byte     <= kbd_front;
        out_from_aux <= 1'b0;
        kbd_head     <= kbd_inc(kbd_head);
      end else if (aux_pop) begin
        out_byte     <= aux_front;
        out_from_aux <= 1'b1;
        aux_head     <= aux_inc(aux_head);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (kbd_p0) kbd_fifo[kbd_tail] <= dec.kbd_byte;
      if (kbd_p1) kbd_fifo[kbd_tail1] <= BYTE_BAT_OK;
      if (aux_p0) aux_fifo[aux_tail] <= dec.aux_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= s1_move || (res_valid && res_stall);
    end
    if (s1_move) begin
      rdata   <= rdata_next;
      irq_kbd <= kbd_pop;
      irq_aux <= aux_pop;
    end
  end

  // Checks
  a_kbd_bound: assert property (@(posedge clk) disable iff (rst)
    kbd_count <= KBD_CW'(KBD_FIFO_DEPTH))
    else $error("keyboard queue count exceeds depth");

  a_irq_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(irq_kbd && irq_aux))
    else $error("both interrupts in one result");

  a_irq_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (irq_kbd || irq_aux)) |-> out_full)
    else $error("interrupt without a full output buffer");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    (!s1_move && !$past(rst)) |=> ($stable(kbd_count) && $stable(aux_count)))
    else $error("queue count changed with no request processed");

endmodule
